// ===== src/sri_pkg.sv =====
// Shared types and constants for the segment/rectangle intersection pipeline.
// No dependencies; used by sri_lane and segment_rect_intersect.
package sri_pkg;

	localparam int COORD_BITS_DEF = 16;

	// tuser kind codes
	localparam logic KIND_RECT = 1'b0;
	localparam logic KIND_SEG  = 1'b1;

	// per-stage load enables for the lane pipeline
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} adv_t;

endpackage

// ===== src/sri_lane.sv =====
// One segment-against-segment test, pipelined over stages s2 to s5.
// Depends on sri_pkg (adv_t).
module sri_lane #(
	parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  sri_pkg::adv_t              adv,
	input  logic signed [COORD_BITS:0] ax,
	input  logic signed [COORD_BITS:0] ay,
	input  logic signed [COORD_BITS:0] bx,
	input  logic signed [COORD_BITS:0] by,
	input  logic signed [COORD_BITS:0] cx,
	input  logic signed [COORD_BITS:0] cy,
	input  logic signed [COORD_BITS:0] dx,
	input  logic signed [COORD_BITS:0] dy,
	output logic                       hit
);

	localparam int W  = COORD_BITS + 1;
	localparam int DW = W + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;

	logic signed [DW-1:0] ex_s2, ey_s2, fx_s2, fy_s2, gx_s2, gy_s2;
	logic signed [PW-1:0] pd_a_s3, pd_b_s3, p1_a_s3, p1_b_s3, p2_a_s3, p2_b_s3;
	logic signed [XW-1:0] den_s4, n1_s4, n2_s4;

	// num/den within [0,1], den nonzero
	function automatic logic in_unit(input logic signed [XW-1:0] num,
	                                 input logic signed [XW-1:0] den);
		logic r;
		if (den > 0)
			r = (num >= 0) && (num <= den);
		else if (den < 0)
			r = (num <= 0) && (num >= den);
		else
			r = 1'b0;
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			ex_s2 <= DW'(dx) - DW'(cx);
			ey_s2 <= DW'(dy) - DW'(cy);
			fx_s2 <= DW'(bx) - DW'(ax);
			fy_s2 <= DW'(by) - DW'(ay);
			gx_s2 <= DW'(ax) - DW'(cx);
			gy_s2 <= DW'(ay) - DW'(cy);
		end
		if (adv.s3) begin
			pd_a_s3 <= PW'(fx_s2) * PW'(ey_s2);
			pd_b_s3 <= PW'(fy_s2) * PW'(ex_s2);
			p1_a_s3 <= PW'(gy_s2) * PW'(ex_s2);
			p1_b_s3 <= PW'(gx_s2) * PW'(ey_s2);
			p2_a_s3 <= PW'(gy_s2) * PW'(fx_s2);
			p2_b_s3 <= PW'(gx_s2) * PW'(fy_s2);
		end
		if (adv.s4) begin
			den_s4 <= XW'(pd_a_s3) - XW'(pd_b_s3);
			n1_s4  <= XW'(p1_a_s3) - XW'(p1_b_s3);
			n2_s4  <= XW'(p2_a_s3) - XW'(p2_b_s3);
		end
		if (adv.s5) begin
			hit <= in_unit(n1_s4, den_s4) && in_unit(n2_s4, den_s4);
		end
	end

endmodule

// ===== src/segment_rect_intersect.sv =====
// Segment/rectangle and segment/segment intersection, six register stages.
// Path: stage 1, stages 2 to 5, output register; one item per cycle while m_tready is high.
// A full stage holds only while the stage after it holds.
// Reset (arst_n, asynchronous, active low) empties every stage; payload is not cleared.
// Depends on sri_pkg and sri_lane.
module segment_rect_intersect #(
	parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// seg_ax, seg_ay, seg_bx, seg_by, other_x, other_y, other_u, other_v
	input  logic [8*COORD_BITS-1:0]   s_tdata,
	// kind
	input  logic [0:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// hit, then zero padding
	output logic [7:0]                m_tdata
);

	localparam int CB = COORD_BITS;
	localparam int W  = CB + 1;
	localparam int NL = 4;

	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
	sri_pkg::adv_t adv;

	logic                 kind_s1;
	logic signed [CB-1:0] ax_s1, ay_s1, bx_s1, by_s1, ox_s1, oy_s1, ou_s1, ov_s1;
	logic signed [W-1:0]  r_s1, b_s1;
	logic signed [W-1:0]  ax_w, ay_w, bx_w, by_w, ox_w, oy_w, ou_w, ov_w;
	logic signed [W-1:0]  l0_dx, l0_dy;
	logic                 ins_a, ins_b;
	logic                 kind_s2, kind_s3, kind_s4, kind_s5;
	logic                 ins_s2, ins_s3, ins_s4, ins_s5;
	logic [NL-1:0]        lane_hit;
	logic                 hit_c;

	// ready chain: a stage takes data when empty or when it moves on
	assign rdy_out  = !m_tvalid || m_tready;
	assign rdy5     = !v5_q || rdy_out;
	assign rdy4     = !v4_q || rdy5;
	assign rdy3     = !v3_q || rdy4;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign s_tready = rdy1;
	assign adv      = '{s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q     <= 1'b0;
			v2_q     <= 1'b0;
			v3_q     <= 1'b0;
			v4_q     <= 1'b0;
			v5_q     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (rdy1)    v1_q     <= s_tvalid;
			if (rdy2)    v2_q     <= v1_q;
			if (rdy3)    v3_q     <= v2_q;
			if (rdy4)    v4_q     <= v3_q;
			if (rdy5)    v5_q     <= v4_q;
			if (rdy_out) m_tvalid <= v5_q;
		end
	end

	// stage 1: unpack, far rectangle corner
	always_ff @(posedge clk) begin
		if (rdy1) begin
			kind_s1 <= s_tuser[0];
			ax_s1   <= s_tdata[0*CB +: CB];
			ay_s1   <= s_tdata[1*CB +: CB];
			bx_s1   <= s_tdata[2*CB +: CB];
			by_s1   <= s_tdata[3*CB +: CB];
			ox_s1   <= s_tdata[4*CB +: CB];
			oy_s1   <= s_tdata[5*CB +: CB];
			ou_s1   <= s_tdata[6*CB +: CB];
			ov_s1   <= s_tdata[7*CB +: CB];
			r_s1    <= W'($signed(s_tdata[4*CB +: CB])) + W'($signed(s_tdata[6*CB +: CB]));
			b_s1    <= W'($signed(s_tdata[5*CB +: CB])) + W'($signed(s_tdata[7*CB +: CB]));
		end
	end

	assign ax_w = W'(ax_s1);
	assign ay_w = W'(ay_s1);
	assign bx_w = W'(bx_s1);
	assign by_w = W'(by_s1);
	assign ox_w = W'(ox_s1);
	assign oy_w = W'(oy_s1);
	assign ou_w = W'(ou_s1);
	assign ov_w = W'(ov_s1);

	// lane 0 is the top edge for a rectangle, or segment C-D
	assign l0_dx = (kind_s1 == sri_pkg::KIND_SEG) ? ou_w : r_s1;
	assign l0_dy = (kind_s1 == sri_pkg::KIND_SEG) ? ov_w : oy_w;

	// both endpoints inside, half-open on the far sides
	assign ins_a = (ax_w >= ox_w) && (ax_w < r_s1) && (ay_w >= oy_w) && (ay_w < b_s1);
	assign ins_b = (bx_w >= ox_w) && (bx_w < r_s1) && (by_w >= oy_w) && (by_w < b_s1);

	sri_lane #(.COORD_BITS(COORD_BITS)) u_lane0 (
		.clk(clk), .adv(adv),
		.ax(ax_w), .ay(ay_w), .bx(bx_w), .by(by_w),
		.cx(ox_w), .cy(oy_w), .dx(l0_dx), .dy(l0_dy),
		.hit(lane_hit[0])
	);

	sri_lane #(.COORD_BITS(COORD_BITS)) u_lane1 (
		.clk(clk), .adv(adv),
		.ax(ax_w), .ay(ay_w), .bx(bx_w), .by(by_w),
		.cx(r_s1), .cy(oy_w), .dx(r_s1), .dy(b_s1),
		.hit(lane_hit[1])
	);

	sri_lane #(.COORD_BITS(COORD_BITS)) u_lane2 (
		.clk(clk), .adv(adv),
		.ax(ax_w), .ay(ay_w), .bx(bx_w), .by(by_w),
		.cx(r_s1), .cy(b_s1), .dx(ox_w), .dy(b_s1),
		.hit(lane_hit[2])
	);

	sri_lane #(.COORD_BITS(COORD_BITS)) u_lane3 (
		.clk(clk), .adv(adv),
		.ax(ax_w), .ay(ay_w), .bx(bx_w), .by(by_w),
		.cx(ox_w), .cy(b_s1), .dx(ox_w), .dy(oy_w),
		.hit(lane_hit[3])
	);

	// sideband travels alongside the lanes
	always_ff @(posedge clk) begin
		if (rdy2) begin
			kind_s2 <= kind_s1;
			ins_s2  <= ins_a && ins_b;
		end
		if (rdy3) begin
			kind_s3 <= kind_s2;
			ins_s3  <= ins_s2;
		end
		if (rdy4) begin
			kind_s4 <= kind_s3;
			ins_s4  <= ins_s3;
		end
		if (rdy5) begin
			kind_s5 <= kind_s4;
			ins_s5  <= ins_s4;
		end
	end

	assign hit_c = (kind_s5 == sri_pkg::KIND_SEG) ? lane_hit[0] : ((|lane_hit) || ins_s5);

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			m_tdata <= {7'b0, hit_c};
		end
	end

	// a blocked input means every stage holds an item
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v1_q && v2_q && v3_q && v4_q && v5_q && m_tvalid))
		else $error("input blocked with an empty stage");

	// an input transfer always lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v1_q)
		else $error("accepted transfer lost at stage 1");

	// a stalled last stage keeps its item and result
	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v5_q && !rdy_out) |=> (v5_q && $stable(kind_s5) && $stable(lane_hit)))
		else $error("stage 5 changed while stalled");

	// a result moves out only when stage 5 has one to give
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		(rdy_out && !v5_q) |=> !m_tvalid)
		else $error("result produced from an empty stage");

endmodule
